### rtl/cssim_pkg.sv
// Shared types and constants for the CPU schedule simulator.
// Depends on nothing; every other file takes names from here by scope.
`timescale 1ns / 1ps

package cssim_pkg;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic CFG_POLICY  = 1'b0;
  localparam logic CFG_QUANTUM = 1'b1;

  localparam logic [2:0] POL_FCFS = 3'd0;
  localparam logic [2:0] POL_SJF  = 3'd1;
  localparam logic [2:0] POL_SRTF = 3'd2;
  localparam logic [2:0] POL_RR   = 3'd3;
  localparam logic [2:0] POL_PRIO = 3'd4;

  localparam logic [15:0] QUANTUM_RESET = 16'd2;
  localparam int OUT_TW = 21;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  proc_id;
    logic [15:0] arrival_time;
    logic [15:0] burst_time;
    logic [7:0]  prio_level;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        result_id;
    logic [OUT_TW-1:0] finish_time;
    logic [OUT_TW-1:0] wait_time;
    logic [OUT_TW-1:0] turnaround_time;
    logic [OUT_TW-1:0] response_time;
    logic              last;
  } out_item_t;

  // Static per-process record written by a load.
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_PREP_RD, ST_PREP_WR, ST_LOOP, ST_SCAN_RD, ST_SCAN_EV,
    ST_SCAN_END, ST_JUMP, ST_RING_RD, ST_RING_CUR, ST_DISP_RD, ST_DISP_SL,
    ST_DISP_EX, ST_PUSH, ST_OUT_RD
  } state_t;

  typedef struct packed {
    logic accept;
    logic start_run;
    logic prep_wr;
    logic scan_init;
    logic scan_ev;
    logic scan_enq;
    logic scan_skip;
    logic jump;
    logic disp_rd;
    logic disp_sl;
    logic disp_ex;
    logic ring_rd;
    logic ring_cur;
    logic push;
    logic out_init;
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    logic is_fcfs;
    logic is_rr;
    logic count_zero;
    logic idx_last;
    logic left_zero;
    logic found;
    logic ring_empty;
    logic rem_zero;
    logic out_busy;
  } stat_t;

endpackage

### rtl/cssim_ctrl.sv
// Sequencer for the schedule simulator: load/run handshake, prepare sweep,
// table scans, dispatch, ready ring and result readout. Uses cssim_pkg.
`timescale 1ns / 1ps

module cssim_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_op,
  output logic              in_stall,
  input  cssim_pkg::stat_t  stat,
  output cssim_pkg::cmd_t   cmd
);

  cssim_pkg::state_t state_r, state_nxt;
  logic enq_r, enq_nxt;
  logic skip_r, skip_nxt;
  logic rdy_r, rdy_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cssim_pkg::ST_IDLE;
      enq_r   <= 1'b0;
      skip_r  <= 1'b0;
      rdy_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      enq_r   <= enq_nxt;
      skip_r  <= skip_nxt;
      rdy_r   <= rdy_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    enq_nxt       = enq_r;
    skip_nxt      = skip_r;
    rdy_nxt       = rdy_r;
    cmd           = '0;
    cmd.scan_enq  = enq_r;
    cmd.scan_skip = skip_r;
    in_stall      = 1'b1;
    case (state_r)
      cssim_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && in_op == cssim_pkg::OP_RUN && !stat.count_zero) begin
          state_nxt = cssim_pkg::ST_START;
        end
      end
      cssim_pkg::ST_START: begin
        cmd.start_run = 1'b1;
        state_nxt     = cssim_pkg::ST_PREP_RD;
      end
      cssim_pkg::ST_PREP_RD: begin
        state_nxt = cssim_pkg::ST_PREP_WR;
      end
      cssim_pkg::ST_PREP_WR: begin
        cmd.prep_wr = 1'b1;
        if (!stat.idx_last) begin
          state_nxt = cssim_pkg::ST_PREP_RD;
        end else if (stat.is_rr) begin
          cmd.scan_init = 1'b1;
          enq_nxt       = 1'b1;
          skip_nxt      = 1'b0;
          state_nxt     = cssim_pkg::ST_SCAN_RD;
        end else begin
          state_nxt = cssim_pkg::ST_LOOP;
        end
      end
      cssim_pkg::ST_LOOP: begin
        if (stat.left_zero) begin
          cmd.out_init = 1'b1;
          rdy_nxt      = 1'b0;
          state_nxt    = cssim_pkg::ST_OUT_RD;
        end else if (stat.is_fcfs) begin
          state_nxt = cssim_pkg::ST_DISP_RD;
        end else if (stat.is_rr && !stat.ring_empty) begin
          state_nxt = cssim_pkg::ST_RING_RD;
        end else begin
          cmd.scan_init = 1'b1;
          enq_nxt       = 1'b0;
          skip_nxt      = 1'b0;
          state_nxt     = cssim_pkg::ST_SCAN_RD;
        end
      end
      cssim_pkg::ST_SCAN_RD: begin
        state_nxt = cssim_pkg::ST_SCAN_EV;
      end
      cssim_pkg::ST_SCAN_EV: begin
        cmd.scan_ev = 1'b1;
        state_nxt   = stat.idx_last ? cssim_pkg::ST_SCAN_END : cssim_pkg::ST_SCAN_RD;
      end
      cssim_pkg::ST_SCAN_END: begin
        if (enq_r) begin
          state_nxt = (skip_r && !stat.rem_zero) ? cssim_pkg::ST_PUSH : cssim_pkg::ST_LOOP;
        end else if (!stat.is_rr && stat.found) begin
          state_nxt = cssim_pkg::ST_DISP_RD;
        end else begin
          state_nxt = cssim_pkg::ST_JUMP;
        end
      end
      cssim_pkg::ST_JUMP: begin
        cmd.jump = 1'b1;
        if (stat.is_rr) begin
          cmd.scan_init = 1'b1;
          enq_nxt       = 1'b1;
          skip_nxt      = 1'b0;
          state_nxt     = cssim_pkg::ST_SCAN_RD;
        end else begin
          state_nxt = cssim_pkg::ST_LOOP;
        end
      end
      cssim_pkg::ST_RING_RD: begin
        cmd.ring_rd = 1'b1;
        state_nxt   = cssim_pkg::ST_RING_CUR;
      end
      cssim_pkg::ST_RING_CUR: begin
        cmd.ring_cur = 1'b1;
        state_nxt    = cssim_pkg::ST_DISP_RD;
      end
      cssim_pkg::ST_DISP_RD: begin
        cmd.disp_rd = 1'b1;
        state_nxt   = cssim_pkg::ST_DISP_SL;
      end
      cssim_pkg::ST_DISP_SL: begin
        cmd.disp_sl = 1'b1;
        state_nxt   = cssim_pkg::ST_DISP_EX;
      end
      cssim_pkg::ST_DISP_EX: begin
        cmd.disp_ex = 1'b1;
        if (stat.is_rr) begin
          cmd.scan_init = 1'b1;
          enq_nxt       = 1'b1;
          skip_nxt      = 1'b1;
          state_nxt     = cssim_pkg::ST_SCAN_RD;
        end else begin
          state_nxt = cssim_pkg::ST_LOOP;
        end
      end
      cssim_pkg::ST_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = cssim_pkg::ST_LOOP;
      end
      cssim_pkg::ST_OUT_RD: begin
        // wait for the entry read (rdy_r), then hold until the result
        // register is free and load one result
        rdy_nxt = 1'b1;
        if (rdy_r && !stat.out_busy) begin
          cmd.out_ld = 1'b1;
          rdy_nxt    = 1'b0;
          state_nxt  = stat.idx_last ? cssim_pkg::ST_IDLE : cssim_pkg::ST_OUT_RD;
        end
      end
      default: begin
        state_nxt = cssim_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/cssim_dp.sv
// Datapath of the schedule simulator: process tables, ready ring, clock,
// scan trackers, dispatch arithmetic and result register. Uses cssim_pkg.
`timescale 1ns / 1ps

module cssim_dp #(
  parameter int MAX_PROCS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data,
  input  cssim_pkg::in_item_t  in_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output cssim_pkg::out_item_t out_data,
  input  cssim_pkg::cmd_t      cmd,
  output cssim_pkg::stat_t     stat
);

  localparam int IW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW  = $clog2(MAX_PROCS + 1);
  localparam int TWN = $clog2((MAX_PROCS + 1) * 65536);
  localparam int TW  = (TWN > cssim_pkg::OUT_TW) ? TWN : cssim_pkg::OUT_TW;
  localparam logic [CW-1:0] MAXC = CW'(MAX_PROCS);
  localparam logic [IW-1:0] LASTI = IW'(MAX_PROCS - 1);

  cssim_pkg::entry_t smem [MAX_PROCS];
  logic [15:0]   rem_mem [MAX_PROCS];
  logic [TW-1:0] first_mem [MAX_PROCS];
  logic [TW-1:0] fin_mem [MAX_PROCS];
  logic [IW-1:0] ring_mem [MAX_PROCS];

  cssim_pkg::entry_t sq_r;
  logic [15:0]   rem_q_r;
  logic [TW-1:0] first_q_r, fin_q_r;
  logic [IW-1:0] ring_q_r;

  logic [2:0]    policy_r;
  logic [15:0]   quantum_r;
  logic [CW-1:0] count_r, idx_r, left_r, fill_r;
  logic [TW-1:0] t_r, ts_r;
  logic [MAX_PROCS-1:0] done_r, queued_r;
  logic [IW-1:0] best_r, cur_r, head_r, tail_r;
  logic [15:0]   bkey_r, minall_r, minfut_r, slice_r;
  logic          found_r, hasall_r, hasfut_r, remz_r, outv_r;
  cssim_pkg::out_item_t out_r;

  logic is_fcfs, is_sjf, is_srtf, is_rr, is_prio;
  assign is_sjf  = policy_r == cssim_pkg::POL_SJF;
  assign is_srtf = policy_r == cssim_pkg::POL_SRTF;
  assign is_rr   = policy_r == cssim_pkg::POL_RR;
  assign is_prio = policy_r == cssim_pkg::POL_PRIO;
  assign is_fcfs = !(is_sjf || is_srtf || is_rr || is_prio);

  logic [IW-1:0] ei, disp_src, rd_idx;
  logic [CW-1:0] done_cnt;
  assign ei       = idx_r[IW-1:0];
  assign done_cnt = count_r - left_r;
  always_comb begin
    if (is_fcfs) begin
      disp_src = done_cnt[IW-1:0];
    end else if (is_rr) begin
      disp_src = cur_r;
    end else begin
      disp_src = best_r;
    end
  end
  // keep the dispatched entry on the read port until the execute step
  assign rd_idx = (cmd.disp_rd || cmd.disp_sl) ? disp_src : ei;

  // scan evaluation of the entry read last cycle
  logic          nd, arrived, pick_hit, enq_hit;
  logic [15:0]   key;
  assign nd       = !done_r[ei];
  assign arrived  = TW'(sq_r.arrival) <= t_r;
  assign key      = is_prio ? {8'd0, sq_r.prio} : rem_q_r;
  assign pick_hit = nd && arrived && (!found_r || key < bkey_r);
  assign enq_hit  = cmd.scan_ev && cmd.scan_enq && nd && arrived && !queued_r[ei] &&
                    !(cmd.scan_skip && ei == cur_r);

  // dispatch arithmetic
  logic [15:0]   q_eff, gap, slice_nxt, newrem;
  logic [TW-1:0] tnew;
  assign q_eff = (quantum_r == 16'd0) ? 16'd1 : quantum_r;
  assign gap   = minfut_r - t_r[15:0];
  always_comb begin
    slice_nxt = rem_q_r;
    if (is_rr) begin
      slice_nxt = (rem_q_r < q_eff) ? rem_q_r : q_eff;
    end else if (is_srtf && hasfut_r && gap < rem_q_r) begin
      slice_nxt = gap;
    end
  end
  assign newrem = rem_q_r - slice_r;
  assign tnew   = ts_r + TW'(slice_r);

  // result fields
  logic [TW-1:0] tat, wt, rsp;
  assign tat = fin_q_r - TW'(sq_r.arrival);
  assign wt  = tat - TW'(sq_r.burst);
  assign rsp = first_q_r - TW'(sq_r.arrival);

  logic ring_we;
  logic [IW-1:0] ring_wd;
  assign ring_we = enq_hit || cmd.push;
  assign ring_wd = cmd.push ? cur_r : ei;

  always_ff @(posedge clk) begin
    sq_r      <= smem[rd_idx];
    rem_q_r   <= rem_mem[rd_idx];
    first_q_r <= first_mem[rd_idx];
    fin_q_r   <= fin_mem[rd_idx];
    ring_q_r  <= ring_mem[head_r];
    if (cmd.accept && in_data.op == cssim_pkg::OP_LOAD && count_r < MAXC) begin
      smem[count_r[IW-1:0]].id      <= in_data.proc_id;
      smem[count_r[IW-1:0]].arrival <= in_data.arrival_time;
      smem[count_r[IW-1:0]].burst   <= (in_data.burst_time == 16'd0) ? 16'd1
                                                                     : in_data.burst_time;
      smem[count_r[IW-1:0]].prio    <= in_data.prio_level;
    end
    if (cmd.prep_wr) begin
      rem_mem[ei] <= sq_r.burst;
    end
    if (cmd.disp_ex) begin
      rem_mem[cur_r] <= newrem;
      if (rem_q_r == sq_r.burst) begin
        first_mem[cur_r] <= ts_r;
      end
      if (newrem == 16'd0) begin
        fin_mem[cur_r] <= tnew;
      end
    end
    if (ring_we) begin
      ring_mem[tail_r] <= ring_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r  <= cssim_pkg::POL_FCFS;
      quantum_r <= cssim_pkg::QUANTUM_RESET;
      count_r   <= '0;
      idx_r     <= '0;
      left_r    <= '0;
      fill_r    <= '0;
      t_r       <= '0;
      ts_r      <= '0;
      done_r    <= '0;
      queued_r  <= '0;
      best_r    <= '0;
      cur_r     <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      bkey_r    <= '0;
      minall_r  <= '0;
      minfut_r  <= '0;
      slice_r   <= '0;
      found_r   <= 1'b0;
      hasall_r  <= 1'b0;
      hasfut_r  <= 1'b0;
      remz_r    <= 1'b0;
      outv_r    <= 1'b0;
      out_r     <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == cssim_pkg::CFG_POLICY) begin
          policy_r <= cfg_data[2:0];
        end else begin
          quantum_r <= cfg_data;
        end
      end
      if (cmd.accept) begin
        if (in_data.op == cssim_pkg::OP_LOAD && count_r < MAXC) begin
          count_r <= count_r + CW'(1);
        end else if (in_data.op == cssim_pkg::OP_CLEAR) begin
          count_r <= '0;
        end
      end
      if (cmd.start_run) begin
        t_r      <= '0;
        done_r   <= '0;
        queued_r <= '0;
        head_r   <= '0;
        tail_r   <= '0;
        fill_r   <= '0;
        left_r   <= count_r;
        idx_r    <= '0;
      end
      if (cmd.scan_init || cmd.out_init) begin
        idx_r    <= '0;
        found_r  <= 1'b0;
        hasall_r <= 1'b0;
        hasfut_r <= 1'b0;
      end else if (cmd.prep_wr || cmd.scan_ev || cmd.out_ld) begin
        idx_r <= idx_r + CW'(1);
      end
      if (cmd.scan_ev) begin
        if (pick_hit) begin
          found_r <= 1'b1;
          bkey_r  <= key;
          best_r  <= ei;
        end
        if (nd && (!hasall_r || sq_r.arrival < minall_r)) begin
          hasall_r <= 1'b1;
          minall_r <= sq_r.arrival;
        end
        if (nd && !arrived && (!hasfut_r || sq_r.arrival < minfut_r)) begin
          hasfut_r <= 1'b1;
          minfut_r <= sq_r.arrival;
        end
      end
      if (ring_we) begin
        tail_r <= (tail_r == LASTI) ? '0 : tail_r + IW'(1);
        fill_r <= fill_r + CW'(1);
        queued_r[ring_wd] <= 1'b1;
      end
      if (cmd.jump) begin
        t_r <= (hasall_r && TW'(minall_r) > t_r) ? TW'(minall_r) : t_r + TW'(1);
      end
      if (cmd.ring_rd) begin
        head_r <= (head_r == LASTI) ? '0 : head_r + IW'(1);
        fill_r <= fill_r - CW'(1);
      end
      if (cmd.ring_cur) begin
        cur_r <= ring_q_r;
        queued_r[ring_q_r] <= 1'b0;
      end
      if (cmd.disp_rd) begin
        cur_r <= disp_src;
      end
      if (cmd.disp_sl) begin
        slice_r <= slice_nxt;
        ts_r    <= (is_fcfs && TW'(sq_r.arrival) > t_r) ? TW'(sq_r.arrival) : t_r;
      end
      if (cmd.disp_ex) begin
        t_r    <= tnew;
        remz_r <= newrem == 16'd0;
        if (newrem == 16'd0) begin
          done_r[cur_r] <= 1'b1;
          left_r        <= left_r - CW'(1);
        end
      end
      if (out_valid && !out_stall) begin
        outv_r <= 1'b0;
      end
      if (cmd.out_ld) begin
        outv_r                <= 1'b1;
        out_r.result_id       <= sq_r.id;
        out_r.finish_time     <= fin_q_r[cssim_pkg::OUT_TW-1:0];
        out_r.wait_time       <= wt[cssim_pkg::OUT_TW-1:0];
        out_r.turnaround_time <= tat[cssim_pkg::OUT_TW-1:0];
        out_r.response_time   <= rsp[cssim_pkg::OUT_TW-1:0];
        out_r.last            <= (idx_r + CW'(1)) == count_r;
      end
    end
  end

  assign out_valid = outv_r;
  assign out_data  = out_r;

  always_comb begin
    stat.is_fcfs    = is_fcfs;
    stat.is_rr      = is_rr;
    stat.count_zero = count_r == '0;
    stat.idx_last   = (idx_r + CW'(1)) == count_r;
    stat.left_zero  = left_r == '0;
    stat.found      = found_r;
    stat.ring_empty = fill_r == '0;
    stat.rem_zero   = remz_r;
    stat.out_busy   = outv_r;
  end

endmodule

### rtl/cpu_schedule_simulator_core.sv
// Top level of the CPU schedule simulator.
// Joins cssim_ctrl and cssim_dp; types come from cssim_pkg.
`timescale 1ns / 1ps

// A load transaction appends one process to a table of MAX_PROCS entries
// (dropped when the table is full); a clear transaction empties it. A run
// transaction simulates the table under the policy register and then
// delivers one result per entry, in load order, the last one flagged. A run
// begins with a prepare sweep, then makes each SJF, SRTF or priority decision
// with a full table scan followed by dispatch; FCFS dispatches in load order
// without a scan, and round robin takes the next process from the ready ring
// and adds a scan per slice. SRTF runs each chosen process until it finishes
// or the next arrival, so its decisions track arrivals rather than ticks.
// Readout loads one result at a time, holding while the output register is
// still full. The input is stalled for the whole run; the last result may
// still wait in the output register while new items are taken.
module cpu_schedule_simulator_core #(
  parameter int MAX_PROCS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cssim_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cssim_pkg::out_item_t out_data
);

  // command and status between sequencer and datapath
  cssim_pkg::cmd_t  cmd;
  cssim_pkg::stat_t stat;

  cssim_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  cssim_dp #(
    .MAX_PROCS (MAX_PROCS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

### rtl/cssim_checker.sv
// Port-level checks for cpu_schedule_simulator_core, bound to the top level.
// Depends on cssim_pkg.
`timescale 1ns / 1ps

module cssim_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input cssim_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input cssim_pkg::out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // loads and clears never produce a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.op != cssim_pkg::OP_RUN |=> !$rose(out_valid))
    else $error("result from a non-run transaction");

  // more results of a run follow: input stays stalled
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last |=> in_stall)
    else $error("input taken before run readout finished");

  // reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind cpu_schedule_simulator_core cssim_checker u_cssim_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
